### rtl/gpd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gpd_pkg
// Shared types and constants of the gradient predictor pixel decoder.
// ----------------------------------------------------------------------------
package gpd_pkg;

  localparam int unsigned GPD_MAX_WIDTH      = 2048;
  localparam int unsigned GPD_COMPONENT_BITS = 8;
  localparam int unsigned GPD_NUM_COMP       = 3;
  localparam int unsigned GPD_CFG_IDX_W      = 3;
  localparam int unsigned GPD_CFG_DATA_W     = 12;

  typedef enum logic [GPD_CFG_IDX_W-1:0] {
    REG_RED_MAX     = 3'd0,
    REG_GREEN_MAX   = 3'd1,
    REG_BLUE_MAX    = 3'd2,
    REG_RED_SHIFT   = 3'd3,
    REG_GREEN_SHIFT = 3'd4,
    REG_BLUE_SHIFT  = 3'd5,
    REG_PACKED_RGB  = 3'd6,
    REG_RECT_WIDTH  = 3'd7
  } gpd_reg_e;

  typedef struct packed {
    logic [7:0]  red_max;
    logic [7:0]  green_max;
    logic [7:0]  blue_max;
    logic [4:0]  red_shift;
    logic [4:0]  green_shift;
    logic [4:0]  blue_shift;
    logic        packed_rgb;
    logic [11:0] rect_width;
  } gpd_cfg_t;

  typedef struct packed {
    logic [31:0] raw_pixel;
    logic        start_of_rect;
  } gpd_in_t;

  typedef struct packed {
    logic [31:0] pixel_out;
    logic [10:0] column;
    logic [15:0] row;
    logic        end_of_row;
  } gpd_out_t;

endpackage : gpd_pkg
`default_nettype wire

### rtl/gpd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gpd_queue
// Two-entry first-in first-out buffer with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module gpd_queue #(
  parameter int unsigned DW = 8
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire logic [DW-1:0] data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic [DW-1:0]      data_o,
  output logic               empty_o
);

  logic [DW-1:0] mem_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("queue count out of range");

  a_ptr_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0 || cnt_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with count");

  a_pop_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_pop && !do_push && cnt_q == 2'd1) |=> empty_o)
    else $error("queue not empty after last pop");

endmodule : gpd_queue
`default_nettype wire

### rtl/gpd_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gpd_front
// Accepts raw pixel words, tracks column and row, and extracts the
// per-component differences.
// ----------------------------------------------------------------------------
module gpd_front
  import gpd_pkg::*;
#(
  parameter int unsigned MAX_WIDTH      = GPD_MAX_WIDTH,
  parameter int unsigned COMPONENT_BITS = GPD_COMPONENT_BITS,
  localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int unsigned CB = COMPONENT_BITS
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire gpd_cfg_t               cfg_i,
  input  wire logic                   accept_i,
  input  wire gpd_in_t                in_i,
  output logic [GPD_NUM_COMP*CB-1:0]  diff_o,
  output logic [CW-1:0]               col_o,
  output logic [15:0]                 row_o,
  output logic                        eor_o
);

  logic [CW-1:0] col_q, col_d;
  logic [15:0]   row_q, row_d;
  logic [CW-1:0] last_col;
  logic [31:0]   word;
  logic [CB-1:0] maxv [GPD_NUM_COMP];
  logic [4:0]    shf  [GPD_NUM_COMP];

  always_comb begin
    if (cfg_i.rect_width == 12'd0) begin
      last_col = '0;
    end else if (32'(cfg_i.rect_width) > 32'(MAX_WIDTH)) begin
      last_col = CW'(MAX_WIDTH - 1);
    end else begin
      last_col = CW'(cfg_i.rect_width - 12'd1);
    end
  end

  always_comb begin
    col_o = in_i.start_of_rect ? '0 : col_q;
    row_o = in_i.start_of_rect ? '0 : row_q;
    eor_o = (col_o >= last_col);
    col_d = col_q;
    row_d = row_q;
    if (accept_i) begin
      if (eor_o) begin
        col_d = '0;
        row_d = row_o + 16'd1;
      end else begin
        col_d = col_o + CW'(1);
        row_d = row_o;
      end
    end
  end

  always_comb begin
    word = cfg_i.packed_rgb
         ? {8'h00, in_i.raw_pixel[7:0], in_i.raw_pixel[15:8], in_i.raw_pixel[23:16]}
         : in_i.raw_pixel;
    maxv[0] = CB'(cfg_i.red_max);
    maxv[1] = CB'(cfg_i.green_max);
    maxv[2] = CB'(cfg_i.blue_max);
    shf[0]  = cfg_i.red_shift;
    shf[1]  = cfg_i.green_shift;
    shf[2]  = cfg_i.blue_shift;
    for (int k = 0; k < GPD_NUM_COMP; k++) begin
      diff_o[k*CB +: CB] = CB'(word >> shf[k]) & maxv[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  a_col_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= CW'(MAX_WIDTH - 1))
    else $error("column counter beyond line store");

  a_eor_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && eor_o) |=> (col_q == '0 && row_q == $past(row_o) + 16'd1))
    else $error("row did not advance after end of row");

  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept_i |=> ($stable(col_q) && $stable(row_q)))
    else $error("position changed without a beat");

endmodule : gpd_front
`default_nettype wire

### rtl/gpd_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gpd_back
// Reads the upper neighbor from the line store, predicts each component
// from its neighbors, reconstructs the pixel and writes the line store back.
// ----------------------------------------------------------------------------
module gpd_back
  import gpd_pkg::*;
#(
  parameter int unsigned MAX_WIDTH      = GPD_MAX_WIDTH,
  parameter int unsigned COMPONENT_BITS = GPD_COMPONENT_BITS,
  localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int unsigned CB = COMPONENT_BITS,
  localparam int unsigned SW = GPD_NUM_COMP * CB
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire gpd_cfg_t      cfg_i,
  input  wire logic          item_valid_i,
  input  wire logic [SW-1:0] item_diff_i,
  input  wire logic [CW-1:0] item_col_i,
  input  wire logic [15:0]   item_row_i,
  input  wire logic          item_eor_i,
  output logic               item_pop_o,
  input  wire logic          out_ready_i,
  output logic               out_push_o,
  output gpd_out_t           out_o
);

  logic [SW-1:0] mem_q [MAX_WIDTH];
  logic [SW-1:0] rd_q;
  logic          byp_q;
  logic [SW-1:0] byp_data_q;

  logic          exec_valid_q;
  logic [SW-1:0] exec_diff_q;
  logic [CW-1:0] exec_col_q;
  logic [15:0]   exec_row_q;
  logic          exec_eor_q;
  logic          exec_fire;

  logic [CB-1:0] left_q [GPD_NUM_COMP];
  logic [CB-1:0] ul_q   [GPD_NUM_COMP];

  logic [SW-1:0]   up_word;
  logic [SW-1:0]   value_word;
  logic [CB-1:0]   maxv    [GPD_NUM_COMP];
  logic [4:0]      shf     [GPD_NUM_COMP];
  logic [CB-1:0]   up_c    [GPD_NUM_COMP];
  logic [CB-1:0]   left_c  [GPD_NUM_COMP];
  logic [CB-1:0]   ul_c    [GPD_NUM_COMP];
  logic [CB+1:0]   pred    [GPD_NUM_COMP];
  logic [CB-1:0]   clamped [GPD_NUM_COMP];
  logic [CB-1:0]   value   [GPD_NUM_COMP];
  logic [31:0]     pixel;

  assign exec_fire  = exec_valid_q && out_ready_i;
  assign item_pop_o = item_valid_i && (!exec_valid_q || exec_fire);
  assign out_push_o = exec_fire;
  assign up_word    = byp_q ? byp_data_q : rd_q;

  always_comb begin
    maxv[0] = CB'(cfg_i.red_max);
    maxv[1] = CB'(cfg_i.green_max);
    maxv[2] = CB'(cfg_i.blue_max);
    shf[0]  = cfg_i.red_shift;
    shf[1]  = cfg_i.green_shift;
    shf[2]  = cfg_i.blue_shift;
    pixel   = '0;
    for (int k = 0; k < GPD_NUM_COMP; k++) begin
      up_c[k]   = (exec_row_q != 16'd0) ? up_word[k*CB +: CB] : '0;
      left_c[k] = (exec_col_q != '0) ? left_q[k] : '0;
      ul_c[k]   = (exec_col_q != '0 && exec_row_q != 16'd0) ? ul_q[k] : '0;
      pred[k]   = {2'b00, up_c[k]} + {2'b00, left_c[k]} - {2'b00, ul_c[k]};
      if (pred[k][CB+1]) begin
        clamped[k] = '0;
      end else if (pred[k] > {2'b00, maxv[k]}) begin
        clamped[k] = maxv[k];
      end else begin
        clamped[k] = pred[k][CB-1:0];
      end
      value[k] = (clamped[k] + exec_diff_q[k*CB +: CB]) & maxv[k];
      value_word[k*CB +: CB] = value[k];
      pixel = pixel | (32'(value[k]) << shf[k]);
    end
  end

  always_comb begin
    out_o.pixel_out  = pixel;
    out_o.column     = 11'(exec_col_q);
    out_o.row        = exec_row_q;
    out_o.end_of_row = exec_eor_q;
  end

  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      mem_q[exec_col_q] <= value_word;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_pop_o) begin
      rd_q        <= mem_q[item_col_i];
      byp_data_q  <= value_word;
      exec_diff_q <= item_diff_i;
      exec_col_q  <= item_col_i;
      exec_row_q  <= item_row_i;
      exec_eor_q  <= item_eor_i;
    end
    if (exec_fire) begin
      for (int k = 0; k < GPD_NUM_COMP; k++) begin
        left_q[k] <= value[k];
        ul_q[k]   <= up_c[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exec_valid_q <= 1'b0;
      byp_q        <= 1'b0;
    end else begin
      if (item_pop_o) begin
        exec_valid_q <= 1'b1;
        byp_q        <= exec_fire && (exec_col_q == item_col_i);
      end else if (exec_fire) begin
        exec_valid_q <= 1'b0;
      end
    end
  end

  a_exec_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec_valid_q && !exec_fire) |=> (exec_valid_q && $stable(exec_col_q)
                                      && $stable(exec_row_q)))
    else $error("stalled pixel lost its slot");

  a_pop_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_pop_o |=> exec_valid_q)
    else $error("popped pixel did not reach execute");

  a_byp_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(byp_q) |-> $past(exec_fire))
    else $error("bypass without a same-cycle write");

endmodule : gpd_back
`default_nettype wire

### rtl/gradient_predictor_pixel_decode.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gradient_predictor_pixel_decode
// Reconstructs gradient-filtered pixels in raster order over a rectangle.
//
//   Channel  Handshake           Payload
//   input    push / full         in_data_i  : raw_pixel, start_of_rect
//   result   pop / empty         out_data_o : pixel_out, column, row, end_of_row
//   config   cfg_we_i            cfg_idx_i, cfg_data_i
//
// One pixel per cycle sustained while no queue is full; each pixel passes the
// pixel queue, execute register and result queue before it can be popped.
// The line store read in the back end is registered and is bypassed when the
// pixel ahead writes the same column. Front and back are decoupled by a
// two-entry queue, results by a second two-entry queue, so either side may
// stall alone. Reset clears all control state; the line store is not cleared.
// ----------------------------------------------------------------------------
module gradient_predictor_pixel_decode
  import gpd_pkg::*;
#(
  parameter int unsigned MAX_WIDTH      = GPD_MAX_WIDTH,
  parameter int unsigned COMPONENT_BITS = GPD_COMPONENT_BITS
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      push,
  output logic                           full,
  input  wire gpd_in_t                   in_data_i,
  output logic                           empty,
  input  wire logic                      pop,
  output gpd_out_t                       out_data_o,
  input  wire logic                      cfg_we_i,
  input  wire logic [GPD_CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [GPD_CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned SW  = GPD_NUM_COMP * COMPONENT_BITS;
  localparam int unsigned MDW = SW + CW + 16 + 1;
  localparam int unsigned ODW = $bits(gpd_out_t);

  gpd_cfg_t cfg_q;
  logic     in_fire;

  logic [SW-1:0]  f_diff;
  logic [CW-1:0]  f_col;
  logic [15:0]    f_row;
  logic           f_eor;
  logic [MDW-1:0] mid_wdata, mid_rdata;
  logic           mid_empty, mid_pop;

  logic           out_full, out_push;
  gpd_out_t       back_out;
  logic [ODW-1:0] out_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.red_max     <= 8'd255;
      cfg_q.green_max   <= 8'd255;
      cfg_q.blue_max    <= 8'd255;
      cfg_q.red_shift   <= 5'd16;
      cfg_q.green_shift <= 5'd8;
      cfg_q.blue_shift  <= 5'd0;
      cfg_q.packed_rgb  <= 1'b1;
      cfg_q.rect_width  <= 12'd1;
    end else if (cfg_we_i) begin
      unique case (gpd_reg_e'(cfg_idx_i))
        REG_RED_MAX:     cfg_q.red_max     <= cfg_data_i[7:0];
        REG_GREEN_MAX:   cfg_q.green_max   <= cfg_data_i[7:0];
        REG_BLUE_MAX:    cfg_q.blue_max    <= cfg_data_i[7:0];
        REG_RED_SHIFT:   cfg_q.red_shift   <= cfg_data_i[4:0];
        REG_GREEN_SHIFT: cfg_q.green_shift <= cfg_data_i[4:0];
        REG_BLUE_SHIFT:  cfg_q.blue_shift  <= cfg_data_i[4:0];
        REG_PACKED_RGB:  cfg_q.packed_rgb  <= cfg_data_i[0];
        REG_RECT_WIDTH:  cfg_q.rect_width  <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  assign in_fire = push && !full;

  gpd_front #(
    .MAX_WIDTH      (MAX_WIDTH),
    .COMPONENT_BITS (COMPONENT_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .accept_i (in_fire),
    .in_i     (in_data_i),
    .diff_o   (f_diff),
    .col_o    (f_col),
    .row_o    (f_row),
    .eor_o    (f_eor)
  );

  assign mid_wdata = {f_eor, f_row, f_col, f_diff};

  gpd_queue #(
    .DW (MDW)
  ) u_mid_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (mid_wdata),
    .full_o  (full),
    .pop_i   (mid_pop),
    .data_o  (mid_rdata),
    .empty_o (mid_empty)
  );

  gpd_back #(
    .MAX_WIDTH      (MAX_WIDTH),
    .COMPONENT_BITS (COMPONENT_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (!mid_empty),
    .item_diff_i  (mid_rdata[SW-1:0]),
    .item_col_i   (mid_rdata[SW +: CW]),
    .item_row_i   (mid_rdata[SW+CW +: 16]),
    .item_eor_i   (mid_rdata[MDW-1]),
    .item_pop_o   (mid_pop),
    .out_ready_i  (!out_full),
    .out_push_o   (out_push),
    .out_o        (back_out)
  );

  gpd_queue #(
    .DW (ODW)
  ) u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (back_out),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (out_rdata),
    .empty_o (empty)
  );

  assign out_data_o = gpd_out_t'(out_rdata);

  a_out_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push |-> !out_full)
    else $error("result written into a full queue");

  a_mid_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_pop |-> !mid_empty)
    else $error("pixel taken from an empty queue");

  a_cfg_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_we_i |=> $stable(cfg_q))
    else $error("configuration changed without a write");

endmodule : gradient_predictor_pixel_decode
`default_nettype wire
